[hdl/uitf_pkg.sv]
package uitf_pkg;

	localparam int MAX_FIELD = 64;
	localparam int PREC_MAX  = 62;
	localparam int VAL_W     = 64;
	localparam int BCD_W     = 80;
	localparam int CNT_W     = 7;
	localparam int S_DATA_W  = 80;
	localparam int S_USER_W  = 10;
	localparam int M_DATA_W  = 8;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	typedef enum logic [2:0] {
		CONV_DEC = 3'd0,
		CONV_OCT = 3'd1,
		CONV_HEXL = 3'd2,
		CONV_HEXU = 3'd3,
		CONV_BIN = 3'd4
	} conv_t;

	typedef enum logic [1:0] {
		SIZE_INT   = 2'd0,
		SIZE_CHAR  = 2'd1,
		SIZE_SHORT = 2'd2,
		SIZE_LONG  = 2'd3
	} size_t_e;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX,
		BASE_BIN
	} base_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BCD,
		ST_COUNT,
		ST_SETUP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             nonzero;
		base_t            base;
		logic             upper;
		logic             alt;
		logic             hasp;
		logic [5:0]       prec;
		logic [CNT_W-1:0] width;
		logic             left;
		logic             fill_zero;
		logic             ptr;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		begin
			if (d < 4'd10)
				c = CH_ZERO + {4'd0, d};
			else
				c = (upper ? CH_UP_A : CH_LOW_A) + {4'd0, d} - 8'd10;
			return c;
		end
	endfunction

endpackage

[hdl/unsigned_integer_text_formatter_top.sv]
// Sequence per field: the sequencer pops a queued item, runs a 64-step shift-and-add-3
// binary to BCD pass for decimal only, counts digits, sets up the field, then emits
// one character per cycle while m_tready allows; a two-entry queue lets the next item
// be accepted while the current field is emitted.
// Reset (arst_n, async, active low) empties the queue, idles the sequencer, drops m_tvalid.
module unsigned_integer_text_formatter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// value[63:0], precision[69:64], field_width[76:70]
	input  logic [uitf_pkg::S_DATA_W-1:0]    s_tdata,
	// size_mode[1:0], conversion[4:2], alternate_form[5], has_precision[6],
	// left_adjust[7], zero_pad[8], pointer_mode[9]
	input  logic [uitf_pkg::S_USER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_char[7:0]
	output logic [uitf_pkg::M_DATA_W-1:0]    m_tdata,
	output logic                             m_tlast,
	// empty_res
	output logic                             m_tuser
);
	import uitf_pkg::*;

	qctl_t qctl;
	job_t  wr_job, rd_job;
	logic  q_full, q_empty, pop;

	uitf_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.qctl     (qctl),
		.q_full   (q_full),
		.job      (wr_job)
	);

	uitf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.qctl   (qctl),
		.wr_job (wr_job),
		.full   (q_full),
		.empty  (q_empty),
		.pop    (pop),
		.rd_job (rd_job)
	);

	uitf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_job    (rd_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

[hdl/uitf_front.sv]
module uitf_front (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [uitf_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic [uitf_pkg::S_USER_W-1:0]    s_tuser,
	output uitf_pkg::qctl_t                  qctl,
	input  logic                             q_full,
	output uitf_pkg::job_t                   job
);
	import uitf_pkg::*;

	logic [VAL_W-1:0] v;
	logic [5:0]       p;
	logic [6:0]       w;
	logic [2:0]       conv;

	always_comb begin
		conv = s_tuser[4:2];
		unique case (size_t_e'(s_tuser[1:0]))
			SIZE_INT:   v = {32'd0, s_tdata[31:0]};
			SIZE_CHAR:  v = {56'd0, s_tdata[7:0]};
			SIZE_SHORT: v = {48'd0, s_tdata[15:0]};
			default:    v = s_tdata[63:0];
		endcase
		p = s_tuser[6] ? s_tdata[69:64] : 6'd0;
		if (p > 6'(PREC_MAX))
			p = 6'(PREC_MAX);
		w = s_tdata[76:70];
		if (w > 7'(MAX_FIELD))
			w = 7'(MAX_FIELD);

		job.value = v;
		job.nonzero = |v;
		unique case (conv)
			CONV_DEC:  job.base = BASE_DEC;
			CONV_OCT:  job.base = BASE_OCT;
			CONV_HEXL, CONV_HEXU: job.base = BASE_HEX;
			default:   job.base = BASE_BIN;
		endcase
		job.upper = (conv == CONV_HEXU);
		job.alt = s_tuser[5];
		job.hasp = s_tuser[6];
		job.prec = p;
		job.width = w;
		job.left = s_tuser[7];
		job.fill_zero = s_tuser[8] & ~s_tuser[7] & ~s_tuser[6];
		job.ptr = s_tuser[9];

		s_tready = ~q_full;
		qctl.push = s_tvalid & ~q_full;
		qctl.full = q_full;
	end

endmodule

[hdl/uitf_fifo.sv]
module uitf_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  uitf_pkg::qctl_t qctl,
	input  uitf_pkg::job_t  wr_job,
	output logic            full,
	output logic            empty,
	input  logic            pop,
	output uitf_pkg::job_t  rd_job
);
	import uitf_pkg::*;

	job_t       mem [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_push = qctl.push & ~full;
	assign do_pop = pop & ~empty;
	assign rd_job = mem[rp_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wp_q <= ~wp_q;
			if (do_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> !(cnt_q == 2'd0 && !$past(do_pop)))
		else $error("queue lost an item");

endmodule

[hdl/uitf_back.sv]
module uitf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  uitf_pkg::job_t                q_job,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [uitf_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);
	import uitf_pkg::*;

	state_t           state_q, state_d;
	job_t             job_q;
	logic [BCD_W-1:0] bcd_q;
	logic [VAL_W-1:0] sh_q;
	logic [5:0]       cnt_q;
	logic [CNT_W-1:0] d0_q, px_q, body_q, total_q, start_q, pstart_q;
	logic [5:0]       idx_q;
	logic             out_valid_q, out_last_q, out_empty_q;
	logic [7:0]       out_char_q;

	logic [BCD_W-1:0] bcd_adj;
	logic [CNT_W-1:0] d0_scan, nd_c, px_c, body_c, total_c, start_c;
	logic [CNT_W-1:0] i7, k7;
	logic [7:0]       ch;
	logic             slot_free, emit, is_last;

	function automatic logic [3:0] digit_at(input job_t j, input logic [BCD_W-1:0] b,
		input logic [5:0] k);
		logic [BCD_W-1:0] s80;
		logic [VAL_W-1:0] s;
		logic [3:0]       d;
		begin
			s80 = b >> {k, 2'b00};
			d = 4'd0;
			unique case (j.base)
				BASE_DEC: d = s80[3:0];
				BASE_OCT: begin
					s = j.value >> ({2'b00, k} * 8'd3);
					d = {1'b0, s[2:0]};
				end
				BASE_HEX: begin
					s = j.value >> {k, 2'b00};
					d = s[3:0];
				end
				default: begin
					s = j.value >> k;
					d = {3'd0, s[0]};
				end
			endcase
			return d;
		end
	endfunction

	assign slot_free = ~out_valid_q | m_tready;
	assign emit = (state_q == ST_EMIT) & slot_free;
	assign i7 = {1'b0, idx_q};
	assign is_last = (total_q == 7'd0) || (i7 + 7'd1 == total_q);

	always_comb begin
		for (int g = 0; g < BCD_W / 4; g++) begin
			bcd_adj[g*4 +: 4] = (bcd_q[g*4 +: 4] >= 4'd5) ? bcd_q[g*4 +: 4] + 4'd3
				: bcd_q[g*4 +: 4];
		end
	end

	always_comb begin
		d0_scan = 7'd1;
		for (int k = 0; k < VAL_W; k++) begin
			if (digit_at(job_q, bcd_q, 6'(k)) != 4'd0)
				d0_scan = 7'(k + 1);
		end
		if (!job_q.nonzero && job_q.hasp && job_q.prec == 6'd0
			&& (!job_q.alt || job_q.base == BASE_HEX))
			d0_scan = 7'd0;
	end

	always_comb begin
		nd_c = ({1'b0, job_q.prec} > d0_q) ? {1'b0, job_q.prec} : d0_q;
		if (job_q.alt && job_q.base == BASE_HEX && (job_q.nonzero || job_q.ptr))
			px_c = 7'd2;
		else if (job_q.alt && job_q.base == BASE_OCT && job_q.nonzero && nd_c == d0_q)
			px_c = 7'd1;
		else
			px_c = 7'd0;
		body_c = nd_c + px_c;
		total_c = (job_q.width > body_c) ? job_q.width : body_c;
		start_c = job_q.left ? 7'd0 : total_c - body_c;
	end

	always_comb begin
		k7 = start_q + body_q - 7'd1 - i7;
		if (px_q != 7'd0 && i7 == pstart_q)
			ch = CH_ZERO;
		else if (px_q == 7'd2 && i7 == pstart_q + 7'd1)
			ch = job_q.upper ? CH_UP_X : CH_LOW_X;
		else if (i7 >= start_q + px_q && i7 < start_q + body_q)
			ch = (k7 < d0_q) ? digit_char(digit_at(job_q, bcd_q, k7[5:0]), job_q.upper)
				: CH_ZERO;
		else
			ch = job_q.fill_zero ? CH_ZERO : CH_SPACE;
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					state_d = (q_job.base == BASE_DEC) ? ST_BCD : ST_COUNT;
				end
			end
			ST_BCD: begin
				if (cnt_q == 6'd63)
					state_d = ST_COUNT;
			end
			ST_COUNT: state_d = ST_SETUP;
			ST_SETUP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free && is_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q <= q_job;
				bcd_q <= '0;
				sh_q <= q_job.value;
				cnt_q <= 6'd0;
			end
			ST_BCD: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], sh_q[VAL_W-1]};
				sh_q <= {sh_q[VAL_W-2:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			ST_COUNT: d0_q <= d0_scan;
			ST_SETUP: begin
				px_q <= px_c;
				body_q <= body_c;
				total_q <= total_c;
				start_q <= start_c;
				pstart_q <= job_q.fill_zero ? 7'd0 : start_c;
				idx_q <= 6'd0;
			end
			ST_EMIT: begin
				if (slot_free)
					idx_q <= idx_q + 6'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= (total_q == 7'd0) ? 8'd0 : ch;
			out_last_q <= is_last;
			out_empty_q <= (total_q == 7'd0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_char_q;
	assign m_tlast = out_last_q;
	assign m_tuser = out_empty_q;

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_empty_q) |-> out_last_q)
		else $error("empty item not marked last");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (total_q == 7'd0 || i7 < total_q))
		else $error("emit index past field");

	a_bcd_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BCD) |-> (job_q.base == BASE_DEC))
		else $error("bcd pass on non-decimal item");

	a_body_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (body_q <= total_q && total_q <= 7'(MAX_FIELD)))
		else $error("field larger than limit");

endmodule
